// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CHK_PROP(label, clk, rst_n, prop, msg)
`define CHK_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/chc20_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher package
// Word types, register indexes, constants and sequencer states.
// ----------------------------------------------------------------------------
package chc20_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DBL_ROUNDS = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR   = 3'd6;

	localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} out_word_t;

	// quarter-round sub-steps: which pair is added and how far the result rotates
	typedef enum logic [1:0] {
		QS_AB16,
		QS_CD12,
		QS_AB8,
		QS_CD7
	} qstep_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_COL,
		ST_DSHUF,
		ST_DIAG,
		ST_UNDIAG,
		ST_FEED,
		ST_EMIT
	} state_t;

endpackage

// ===== design/chc20_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 shared add / xor / rotate unit
// One quarter-round sub-step: sum = p + q, mix = (r ^ sum) <<< n.
// ----------------------------------------------------------------------------
module chc20_alu (
	input  logic [31:0]       p,
	input  logic [31:0]       q,
	input  logic [31:0]       r,
	input  chc20_pkg::qstep_t step,
	output logic [31:0]       sum,
	output logic [31:0]       mix
);

	logic [31:0] x;

	assign sum = p + q;
	assign x   = r ^ sum;

	always_comb begin
		case (step)
			chc20_pkg::QS_AB16: mix = {x[15:0], x[31:16]};
			chc20_pkg::QS_CD12: mix = {x[19:0], x[31:20]};
			chc20_pkg::QS_AB8:  mix = {x[23:0], x[31:24]};
			chc20_pkg::QS_CD7:  mix = {x[24:0], x[31:25]};
			default:            mix = x;
		endcase
	end

endmodule

// ===== design/chacha20_stream_cipher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core
// XORs a byte stream with the ChaCha20 keystream (key, nonce, block counter).
// ----------------------------------------------------------------------------
// While a keystream block is held, a word is taken and its result sits in the
// output register the next cycle, so words flow one per cycle when the sink
// keeps up. A block is made by one shared 32-bit add/xor/rotate unit doing one
// quarter-round sub-step per cycle: a load, 10 double rounds (16 column steps,
// a diagonal shuffle, 16 diagonal steps, an unshuffle) and a feed-forward of
// all 16 words. The first word of a message is held until a block is made,
// then sent from the EMIT state; after the 64th word of a block (unless marked
// last) the core is busy making the next block. Configuration writes are taken
// only while no block is being made; a key or nonce write made mid-message
// applies from the next block, an initial counter write from the next message.
`include "assert_macros.svh"

module chacha20_stream_cipher_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  chc20_pkg::in_word_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output chc20_pkg::out_word_t                 out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chc20_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [chc20_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration
	logic [63:0] key_q [4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [31:0] init_ctr_q;

	// sequencer and stream position
	chc20_pkg::state_t state_q, state_d;
	logic [3:0]  cnt_q;
	logic [3:0]  dr_q;
	logic [5:0]  pos_q;
	logic [31:0] ctr_q;
	logic        ks_ready_q;
	logic        out_valid_q;

	// payload
	logic [31:0]          w_q [16];
	logic [31:0]          w_d [16];
	logic [31:0]          w_tmp [16];
	logic [31:0]          init_w [16];
	chc20_pkg::in_word_t  pend_q;
	chc20_pkg::out_word_t out_q;

	// control decode
	logic                 acc;
	logic                 out_free;
	logic                 emit;
	logic                 start_msg;
	logic                 feed_done;
	logic                 in_round;
	chc20_pkg::in_word_t  byte_sel;
	logic [31:0]          ks_word;
	logic [7:0]           ks_byte;

	// shared unit
	chc20_pkg::qstep_t    qstep;
	logic [31:0]          alu_p, alu_q, alu_r;
	logic [31:0]          alu_sum, alu_mix;

	assign out_free = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign qstep    = chc20_pkg::qstep_t'(cnt_q[1:0]);
	assign in_round = (state_q == chc20_pkg::ST_COL) || (state_q == chc20_pkg::ST_DIAG);

	always_comb begin
		init_w[0]  = chc20_pkg::SIGMA_0;
		init_w[1]  = chc20_pkg::SIGMA_1;
		init_w[2]  = chc20_pkg::SIGMA_2;
		init_w[3]  = chc20_pkg::SIGMA_3;
		init_w[4]  = key_q[0][31:0];
		init_w[5]  = key_q[0][63:32];
		init_w[6]  = key_q[1][31:0];
		init_w[7]  = key_q[1][63:32];
		init_w[8]  = key_q[2][31:0];
		init_w[9]  = key_q[2][63:32];
		init_w[10] = key_q[3][31:0];
		init_w[11] = key_q[3][63:32];
		init_w[12] = ctr_q;
		init_w[13] = nonce_lo_q[31:0];
		init_w[14] = nonce_lo_q[63:32];
		init_w[15] = nonce_hi_q;
	end

	// keystream byte straight from the finished state words, little-endian
	assign ks_word = w_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chc20_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		emit      = 1'b0;
		start_msg = 1'b0;
		feed_done = 1'b0;
		byte_sel  = in_data;
		case (state_q)
			chc20_pkg::ST_IDLE: begin
				in_ready  = out_free;
				cfg_ready = 1'b1;
				if (acc) begin
					if (ks_ready_q) begin
						emit = 1'b1;
						if (!in_data.last_in && pos_q == 6'd63) begin
							state_d = chc20_pkg::ST_LOAD;
						end
					end else begin
						start_msg = 1'b1;
						state_d   = chc20_pkg::ST_LOAD;
					end
				end
			end
			chc20_pkg::ST_LOAD: begin
				state_d = chc20_pkg::ST_COL;
			end
			chc20_pkg::ST_COL: begin
				if (cnt_q == 4'd15) begin
					state_d = chc20_pkg::ST_DSHUF;
				end
			end
			chc20_pkg::ST_DSHUF: begin
				state_d = chc20_pkg::ST_DIAG;
			end
			chc20_pkg::ST_DIAG: begin
				if (cnt_q == 4'd15) begin
					state_d = chc20_pkg::ST_UNDIAG;
				end
			end
			chc20_pkg::ST_UNDIAG: begin
				if (dr_q == 4'(chc20_pkg::DBL_ROUNDS - 1)) begin
					state_d = chc20_pkg::ST_FEED;
				end else begin
					state_d = chc20_pkg::ST_COL;
				end
			end
			chc20_pkg::ST_FEED: begin
				if (cnt_q == 4'd15) begin
					feed_done = 1'b1;
					// a message's first byte is still waiting
					state_d   = ks_ready_q ? chc20_pkg::ST_IDLE : chc20_pkg::ST_EMIT;
				end
			end
			chc20_pkg::ST_EMIT: begin
				byte_sel = pend_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = chc20_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chc20_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Counters, position and control flags
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			dr_q        <= '0;
			pos_q       <= '0;
			ctr_q       <= '0;
			ks_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_round || state_q == chc20_pkg::ST_FEED) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				cnt_q <= '0;
			end

			if (state_q == chc20_pkg::ST_UNDIAG) begin
				dr_q <= (dr_q == 4'(chc20_pkg::DBL_ROUNDS - 1)) ? 4'd0 : dr_q + 4'd1;
			end

			if (start_msg) begin
				ctr_q <= init_ctr_q;
			end

			if (feed_done) begin
				ks_ready_q <= 1'b1;
			end

			if (emit) begin
				if (byte_sel.last_in) begin
					pos_q      <= '0;
					ks_ready_q <= 1'b0;
				end else if (pos_q == 6'd63) begin
					pos_q <= '0;
					ctr_q <= ctr_q + 32'd1;
				end else begin
					pos_q <= pos_q + 6'd1;
				end
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0]   <= '0;
			key_q[1]   <= '0;
			key_q[2]   <= '0;
			key_q[3]   <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				chc20_pkg::CFG_KEY_0:    key_q[0]   <= cfg_data;
				chc20_pkg::CFG_KEY_1:    key_q[1]   <= cfg_data;
				chc20_pkg::CFG_KEY_2:    key_q[2]   <= cfg_data;
				chc20_pkg::CFG_KEY_3:    key_q[3]   <= cfg_data;
				chc20_pkg::CFG_NONCE_LO: nonce_lo_q <= cfg_data;
				chc20_pkg::CFG_NONCE_HI: nonce_hi_q <= cfg_data[31:0];
				chc20_pkg::CFG_INIT_CTR: init_ctr_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Shared unit: quarter-rounds always work on column 0 (words 0, 4, 8, 12);
	// the rows are rotated so each column in turn lands there.
	// ------------------------------------------------------------------------
	always_comb begin
		if (state_q == chc20_pkg::ST_FEED) begin
			alu_p = w_q[0];
			alu_q = init_w[cnt_q];
			alu_r = w_q[12];
		end else if (cnt_q[0]) begin
			alu_p = w_q[8];
			alu_q = w_q[12];
			alu_r = w_q[4];
		end else begin
			alu_p = w_q[0];
			alu_q = w_q[4];
			alu_r = w_q[12];
		end
	end

	chc20_alu u_alu (
		.p    (alu_p),
		.q    (alu_q),
		.r    (alu_r),
		.step (qstep),
		.sum  (alu_sum),
		.mix  (alu_mix)
	);

	always_comb begin
		w_tmp = w_q;
		if (cnt_q[0]) begin
			w_tmp[8] = alu_sum;
			w_tmp[4] = alu_mix;
		end else begin
			w_tmp[0]  = alu_sum;
			w_tmp[12] = alu_mix;
		end
	end

	always_comb begin
		w_d = w_q;
		case (state_q)
			chc20_pkg::ST_LOAD: begin
				w_d = init_w;
			end
			chc20_pkg::ST_COL, chc20_pkg::ST_DIAG: begin
				if (qstep == chc20_pkg::QS_CD7) begin
					// quarter-round done: next column into place
					for (int r = 0; r < 4; r++) begin
						for (int j = 0; j < 4; j++) begin
							w_d[4*r+j] = w_tmp[4*r+((j+1)%4)];
						end
					end
				end else begin
					w_d = w_tmp;
				end
			end
			chc20_pkg::ST_DSHUF: begin
				// row r left by r: diagonals become columns
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						w_d[4*r+j] = w_q[4*r+((j+r)%4)];
					end
				end
			end
			chc20_pkg::ST_UNDIAG: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						w_d[4*r+j] = w_q[4*r+((j+4-r)%4)];
					end
				end
			end
			chc20_pkg::ST_FEED: begin
				// words stream past word 0 and get their input word added back
				for (int i = 0; i < 15; i++) begin
					w_d[i] = w_q[i+1];
				end
				w_d[15] = alu_sum;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
		if (start_msg) begin
			pend_q <= in_data;
		end
		if (emit) begin
			out_q.out_byte <= byte_sel.data_byte ^ ks_byte;
			out_q.last_out <= byte_sel.last_in;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------------
	`CHK_PROP(a_blk_after_63, clk, arst_n, (acc && ks_ready_q && !in_data.last_in && pos_q == 6'd63) |=> (state_q == chc20_pkg::ST_LOAD), "no new block after byte 63")
	`CHK_PROP(a_last_clears, clk, arst_n, (acc && in_data.last_in) |=> !ks_ready_q, "keystream still marked ready after last word")
	`CHK_PROP(a_emit_state, clk, arst_n, (state_q == chc20_pkg::ST_EMIT) |-> (ks_ready_q && pos_q == 6'd0), "pending word emitted without a fresh block")
	`CHK_PROP(a_out_source, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q == chc20_pkg::ST_EMIT) || $past(acc)), "output word with no source")
	`CHK_PROP(a_cnt_idle, clk, arst_n, (state_q == chc20_pkg::ST_IDLE) |-> (cnt_q == 4'd0 && dr_q == 4'd0), "step counters not cleared when idle")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core testbench
// Sends byte messages with random source gaps and sink stalls. Each output word
// is predicted by a local ChaCha20 keystream generator and checked in order.
// ----------------------------------------------------------------------------
module tb_top;
	import chc20_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int BLOCK_SETTLE = 400;	// room for a whole block build
	localparam int LONG_HOLD = 1000;
	localparam int TARGET_WORDS = 1600;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;	// no register behind it

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow registers and keystream state
	logic [63:0] key_reg [4];
	logic [63:0] nonce_lo_reg;
	logic [31:0] nonce_hi_reg;
	logic [31:0] init_ctr_reg;
	logic [31:0] block_ctr;
	logic [7:0] ks_bytes [64];
	logic [5:0] ks_pos;
	logic ks_live;
	logic [31:0] mix_w [16];

	out_word_t expected_cipher_q [$];
	int mismatch_count = 0;
	int words_sent = 0;
	int burst_left = 0;
	longint cycle_count = 0;
	bit hold_req = 1'b0;

	chacha20_stream_cipher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void qround(input int a, input int b, input int c, input int d);
		mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rot_left(mix_w[d] ^ mix_w[a], 16);
		mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rot_left(mix_w[b] ^ mix_w[c], 12);
		mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rot_left(mix_w[d] ^ mix_w[a], 8);
		mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rot_left(mix_w[b] ^ mix_w[c], 7);
	endfunction

	// builds the 64 keystream bytes for block_ctr from the shadow registers
	function automatic void refill_keystream();
		logic [31:0] seed_w [16];
		logic [31:0] v;
		seed_w[0] = SIGMA_0;
		seed_w[1] = SIGMA_1;
		seed_w[2] = SIGMA_2;
		seed_w[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			seed_w[4 + 2 * i] = key_reg[i][31:0];
			seed_w[5 + 2 * i] = key_reg[i][63:32];
		end
		seed_w[12] = block_ctr;
		seed_w[13] = nonce_lo_reg[31:0];
		seed_w[14] = nonce_lo_reg[63:32];
		seed_w[15] = nonce_hi_reg;
		for (int i = 0; i < 16; i++) mix_w[i] = seed_w[i];
		for (int r = 0; r < DBL_ROUNDS; r++) begin
			qround(0, 4, 8, 12);
			qround(1, 5, 9, 13);
			qround(2, 6, 10, 14);
			qround(3, 7, 11, 15);
			qround(0, 5, 10, 15);
			qround(1, 6, 11, 12);
			qround(2, 7, 8, 13);
			qround(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) begin
			v = mix_w[i] + seed_w[i];
			for (int k = 0; k < 4; k++) ks_bytes[4 * i + k] = v[8 * k +: 8];
		end
	endfunction

	function automatic void predict_cipher_byte(input in_word_t w);
		out_word_t e;
		if (!ks_live) begin
			block_ctr = init_ctr_reg;
			ks_pos = '0;
			refill_keystream();
			ks_live = 1'b1;
		end
		e.out_byte = w.data_byte ^ ks_bytes[ks_pos];
		e.last_out = w.last_in;
		expected_cipher_q.push_back(e);
		if (w.last_in) begin
			ks_pos = '0;
			ks_live = 1'b0;
		end else if (ks_pos == 6'd63) begin
			// next block is built straight away, with the registers as they stand
			ks_pos = '0;
			block_ctr = block_ctr + 32'd1;
			refill_keystream();
		end else begin
			ks_pos = ks_pos + 6'd1;
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_KEY_0:    key_reg[0] = data;
			CFG_KEY_1:    key_reg[1] = data;
			CFG_KEY_2:    key_reg[2] = data;
			CFG_KEY_3:    key_reg[3] = data;
			CFG_NONCE_LO: nonce_lo_reg = data;
			CFG_NONCE_HI: nonce_hi_reg = data[31:0];
			CFG_INIT_CTR: init_ctr_reg = data[31:0];
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cipher_q.size() == 0) begin
				$error("unexpected word: out_byte %02h last_out %0b",
					out_data.out_byte, out_data.last_out);
				mismatch_count++;
			end else begin
				e = expected_cipher_q.pop_front();
				if (out_data.out_byte !== e.out_byte) begin
					$error("out_byte: expected %02h, actual %02h",
						e.out_byte, out_data.out_byte);
					mismatch_count++;
				end
				if (out_data.last_out !== e.last_out) begin
					$error("last_out: expected %0b, actual %0b",
						e.last_out, out_data.last_out);
					mismatch_count++;
				end
			end
		end
	end

	// sink pacing: stall pattern segments, plus a long hold-off on request
	initial begin : sink_pacing
		int seg_left;
		int mode;
		logic [15:0] pat;
		seg_left = 0;
		mode = 0;
		pat = 16'hffff;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(20, 200);
				pat = 16'($urandom) | 16'h0001;
			end
			seg_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					out_ready <= pat[0];
					pat = {pat[0], pat[15:1]};
				end
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		in_word_t w;
		int gap;
		w.data_byte = b;
		w.last_in = l;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		predict_cipher_byte(w);
	endtask

	task automatic send_message(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
	endtask

	// source stops until every word is back and any block build has finished
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_cipher_q.size() != 0) @(posedge clk);
		repeat (BLOCK_SETTLE) @(posedge clk);
	endtask

	task automatic write_one(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	// narrow registers get junk in the upper half, which must be dropped
	task automatic write_regs(input logic [63:0] k0, k1, k2, k3, n_lo,
			input logic [31:0] n_hi, ctr);
		wait_idle();
		write_one(CFG_KEY_0, k0);
		write_one(CFG_KEY_1, k1);
		write_one(CFG_KEY_2, k2);
		write_one(CFG_KEY_3, k3);
		write_one(CFG_NONCE_LO, n_lo);
		write_one(CFG_NONCE_HI, {$urandom, n_hi});
		write_one(CFG_INIT_CTR, {$urandom, ctr});
		if ($urandom_range(0, 1) == 0)
			write_one(CFG_SPARE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [31:0] ctr;
		case ($urandom_range(0, 4))
			0: ctr = 32'hffff_ffff;
			1: ctr = 32'hffff_fffe;
			2: ctr = '0;
			default: ctr = $urandom;
		endcase
		write_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, $urandom, ctr);
	endtask

	// register defaults: zero key and nonce, counter starting at one
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b1);
	endtask

	task automatic test_known_vector();
		write_regs(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
			64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
			64'h4a00_0000_0000_0000, 32'h0, 32'h1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'hfe, 1'b1);
		send_byte(8'h5a, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// all-ones with the counter wrapping across two block boundaries, then all-zeros
	task automatic test_config_extremes();
		write_regs('1, '1, '1, '1, '1, '1, 32'hffff_ffff);
		send_message(130, 1'b1);
		write_regs('0, '0, '0, '0, '0, '0, 32'h0);
		send_message(65, 1'b1);
	endtask

	// new key lands only on the block built after the write
	task automatic test_mid_message_config();
		random_config();
		send_message(64, 1'b0);
		random_config();
		send_message(70, 1'b1);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		send_message(150, 1'b1);
	endtask

	task automatic test_random_messages();
		int len;
		while (words_sent < TARGET_WORDS) begin
			if ($urandom_range(0, 5) == 0)
				random_config();
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: len = $urandom_range(1, 8);
				8, 9, 10, 11, 12, 13, 14: len = $urandom_range(9, 70);
				15, 16, 17: len = $urandom_range(60, 140);
				18: len = 64;
				default: len = 128;
			endcase
			// an open message runs on into the next one
			send_message(len, $urandom_range(0, 7) != 0);
		end
	endtask

	initial begin : main_seq
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		nonce_lo_reg = '0;
		nonce_hi_reg = '0;
		init_ctr_reg = 32'd1;
		block_ctr = '0;
		ks_pos = '0;
		ks_live = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_known_vector();
		test_config_extremes();
		test_mid_message_config();
		test_backpressure();
		test_random_messages();
		wait_idle();
		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/chc20_pkg.sv
design/chc20_alu.sv
design/chacha20_stream_cipher_core.sv
sim/tb_top.sv
